[hdl/downmix_linear_resampler_assert.svh]
// Assertion helpers. Each expects clk and rst_n in the scope where it is used.
`ifndef DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH
`define DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH

`define DLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/dlr_pkg.sv]
package dlr_pkg;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_RUN         = 8;

  localparam int CHAN_W     = 32;
  localparam int PCM_W      = 16;
  localparam int SAMPLE_W   = 18;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int STEP_W     = 21;
  localparam int PHASE_W    =
    ((PHASE_FRAC_BITS + 1 > STEP_W) ? PHASE_FRAC_BITS + 1 : STEP_W) + 1;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = (PHASE_FRAC_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int PROD_W     = DIFF_W + PHASE_FRAC_BITS;
  localparam int V_W        = PROD_W + 1;
  localparam int SCALE_SH   = 15;
  localparam int W_W        = V_W + SCALE_SH;
  localparam int DIV_SH     = 15 + PHASE_FRAC_BITS;
  localparam int S_W        = W_W - DIV_SH;
  localparam int RUN_W      = $clog2(MAX_RUN + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FMT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_INPUT = 2'd2;

  localparam logic [1:0] FMT_INT16   = 2'd0;
  localparam logic [1:0] FMT_FLOAT32 = 2'd1;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 21'd196608;
  localparam logic [1:0]        SAMPLE_FMT_RST = FMT_INT16;
  localparam logic              STEREO_RST     = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [2:0]                 state_t;

  localparam sample_t Q15_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t Q15_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [PCM_W-1:0] PCM_MAX = {1'b0, {(PCM_W-1){1'b1}}};
  localparam logic [PCM_W-1:0] PCM_MIN = {1'b1, {(PCM_W-1){1'b0}}};

endpackage

[hdl/downmix_linear_resampler.sv]
// Channel  Direction  Width                 Contents
// in_      slave      tdata 64, tuser 1     two raw channel words, silent flag
// out_     master     tdata 16, tlast 1     resampled mono sample, last of run
// cfg_     slave      index 2, data 21      phase_step, sample_format, stereo_input
//
// A frame is decoded when it is accepted and, in stereo mode, its two channels
// are averaged in DEC2; each output sample then passes through the loop check,
// the 4-bit digit-serial multiplier that forms (cur - prev) * phase, and the
// add, scale and output steps, and a last loop check closes the run.
// A silent frame is accepted and produces nothing.
// Reset is synchronous and active low; it restores the configuration registers and clears
// the previous sample and the phase. A stalled output holds only the output
// step; a new frame is accepted as soon as the previous run is complete.
`include "downmix_linear_resampler_assert.svh"

module downmix_linear_resampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] first_channel, [63:32] second_channel
  input  logic        in_tuser,   // [0] silent_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] pcm_sample
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int PF      = dlr_pkg::PHASE_FRAC_BITS;
  localparam int PH_W    = dlr_pkg::PHASE_W;
  localparam int SMP_W   = dlr_pkg::SAMPLE_W;
  localparam int DF_W    = dlr_pkg::DIFF_W;
  localparam int DG_W    = dlr_pkg::DIGIT_W;
  localparam int SH_W    = dlr_pkg::NUM_DIGITS * dlr_pkg::DIGIT_W;
  localparam int VW      = dlr_pkg::V_W;
  localparam int WW      = dlr_pkg::W_W;
  localparam int SW      = dlr_pkg::S_W;
  localparam int PW      = dlr_pkg::PCM_W;
  localparam int RW      = dlr_pkg::RUN_W;
  localparam int DCW     = dlr_pkg::DCNT_W;

  localparam dlr_pkg::state_t ST_IDLE  = 3'd0;
  localparam dlr_pkg::state_t ST_DEC2  = 3'd1;
  localparam dlr_pkg::state_t ST_LOOP  = 3'd2;
  localparam dlr_pkg::state_t ST_MUL   = 3'd3;
  localparam dlr_pkg::state_t ST_VSUM  = 3'd4;
  localparam dlr_pkg::state_t ST_SCALE = 3'd5;
  localparam dlr_pkg::state_t ST_EMIT  = 3'd6;

  localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << PF;

  function automatic dlr_pkg::sample_t decode_word(input logic [31:0] w,
                                                   input logic [1:0]  fmt);
    logic [7:0]       ex;
    logic [23:0]      man;
    logic [7:0]       sh;
    logic [23:0]      mag;
    dlr_pkg::sample_t res;
    ex  = w[30:23];
    man = {1'b1, w[22:0]};
    sh  = 8'd135 - ex;
    mag = man >> sh[4:0];
    res = '0;
    case (fmt)
      dlr_pkg::FMT_INT16: begin
        res = {{(SMP_W-16){w[15]}}, w[15:0]};
      end
      dlr_pkg::FMT_FLOAT32: begin
        if (ex == 8'hff) begin
          if (w[22:0] != 23'd0) begin
            res = '0;
          end else begin
            res = w[31] ? dlr_pkg::Q15_MIN : dlr_pkg::Q15_MAX;
          end
        end else if (ex >= 8'd135) begin
          res = w[31] ? dlr_pkg::Q15_MIN : dlr_pkg::Q15_MAX;
        end else if (ex < 8'd112) begin
          res = '0;
        end else if (w[31]) begin
          if (mag >= 24'd131072) begin
            res = dlr_pkg::Q15_MIN;
          end else begin
            res = dlr_pkg::sample_t'(0) - dlr_pkg::sample_t'({1'b0, mag[16:0]});
          end
        end else begin
          if (mag >= 24'd131071) begin
            res = dlr_pkg::Q15_MAX;
          end else begin
            res = {1'b0, mag[16:0]};
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  dlr_pkg::state_t                state_r, state_nxt;
  logic [dlr_pkg::STEP_W-1:0]     phase_step_r, phase_step_nxt;
  logic [1:0]                     fmt_r, fmt_nxt;
  logic                           stereo_r, stereo_nxt;
  dlr_pkg::sample_t               prev_r, prev_nxt;
  logic [PH_W-1:0]                phase_r, phase_nxt;
  dlr_pkg::sample_t               cur_r, cur_nxt;
  logic [dlr_pkg::CHAN_W-1:0]     ch2_r, ch2_nxt;
  logic [RW-1:0]                  run_r, run_nxt;
  logic [DCW-1:0]                 dcnt_r, dcnt_nxt;
  logic signed [DF_W-1:0]         diff_r, diff_nxt;
  logic [SH_W-1:0]                phsh_r, phsh_nxt;
  logic signed [VW-1:0]           acc_r, acc_nxt;
  logic signed [WW-1:0]           w_r, w_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [PW-1:0]                  out_data_r, out_data_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [31:0]                    dec_word;
  dlr_pkg::sample_t               dec_val;
  logic signed [SMP_W:0]          sum;
  logic                           phase_lt_one;
  logic                           out_free;
  logic signed [DF_W+DG_W:0]      prod;
  logic signed [VW-1:0]           prev_ext;
  logic signed [WW-1:0]           acc_ext;
  logic [PH_W-1:0]                step_sum;
  logic signed [SW-1:0]           s_hi;
  logic signed [SW-1:0]           s_val;
  logic                           round_up;
  logic                           sat_hi;
  logic                           sat_lo;
  logic [PW-1:0]                  pcm;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign dec_word     = (state_r == ST_IDLE) ? in_tdata[31:0] : ch2_r;
  assign dec_val      = decode_word(dec_word, fmt_r);
  assign sum          = {dec_val[SMP_W-1], dec_val} + {cur_r[SMP_W-1], cur_r};
  assign phase_lt_one = (phase_r[PH_W-1:PF] == '0);
  assign out_free     = !out_valid_r || out_tready;
  assign prod         = diff_r * $signed({1'b0, phsh_r[SH_W-1 -: DG_W]});
  assign prev_ext     = VW'(prev_r);
  assign acc_ext      = WW'(acc_r);
  assign step_sum     = phase_r + PH_W'(phase_step_r);

  assign s_hi     = w_r[WW-1:dlr_pkg::DIV_SH];
  assign round_up = w_r[WW-1] && (w_r[dlr_pkg::DIV_SH-1:0] != '0);
  assign s_val    = s_hi + $signed({{(SW-1){1'b0}}, round_up});
  assign sat_hi   = !s_val[SW-1] && (s_val[SW-2:PW-1] != '0);
  assign sat_lo   = s_val[SW-1] && (s_val[SW-2:PW-1] != '1);
  assign pcm      = sat_hi ? dlr_pkg::PCM_MAX : (sat_lo ? dlr_pkg::PCM_MIN : s_val[PW-1:0]);

  always_comb begin
    state_nxt      = state_r;
    phase_step_nxt = phase_step_r;
    fmt_nxt        = fmt_r;
    stereo_nxt     = stereo_r;
    prev_nxt       = prev_r;
    phase_nxt      = phase_r;
    cur_nxt        = cur_r;
    ch2_nxt        = ch2_r;
    run_nxt        = run_r;
    dcnt_nxt       = dcnt_r;
    diff_nxt       = diff_r;
    phsh_nxt       = phsh_r;
    acc_nxt        = acc_r;
    w_nxt          = w_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    if (cfg_valid) begin
      case (cfg_index)
        dlr_pkg::REG_PHASE_STEP:   phase_step_nxt = cfg_data;
        dlr_pkg::REG_SAMPLE_FMT:   fmt_nxt        = cfg_data[1:0];
        dlr_pkg::REG_STEREO_INPUT: stereo_nxt     = cfg_data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && !in_tuser) begin
          cur_nxt   = dec_val;
          ch2_nxt   = in_tdata[63:32];
          state_nxt = stereo_r ? ST_DEC2 : ST_LOOP;
        end
      end
      ST_DEC2: begin
        cur_nxt   = sum[SMP_W:1];
        state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (phase_lt_one && (run_r != RW'(dlr_pkg::MAX_RUN))) begin
          diff_nxt  = {cur_r[SMP_W-1], cur_r} - {prev_r[SMP_W-1], prev_r};
          phsh_nxt  = SH_W'(phase_r[PF-1:0]);
          acc_nxt   = '0;
          dcnt_nxt  = DCW'(dlr_pkg::NUM_DIGITS - 1);
          state_nxt = ST_MUL;
        end else begin
          phase_nxt = phase_lt_one ? '0 : (phase_r - PHASE_ONE);
          prev_nxt  = cur_r;
          run_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        acc_nxt  = (acc_r <<< DG_W) + VW'(prod);
        phsh_nxt = phsh_r << DG_W;
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == '0) begin
          state_nxt = ST_VSUM;
        end
      end
      ST_VSUM: begin
        acc_nxt   = acc_r + (prev_ext <<< PF);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        w_nxt     = (acc_ext <<< dlr_pkg::SCALE_SH) - acc_ext;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pcm;
          out_last_nxt  = (step_sum[PH_W-1:PF] != '0)
                          || (run_r == RW'(dlr_pkg::MAX_RUN - 1));
          phase_nxt     = step_sum;
          run_nxt       = run_r + RW'(1);
          state_nxt     = ST_LOOP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_step_r <= dlr_pkg::PHASE_STEP_RST;
      fmt_r        <= dlr_pkg::SAMPLE_FMT_RST;
      stereo_r     <= dlr_pkg::STEREO_RST;
      prev_r       <= '0;
      phase_r      <= '0;
      run_r        <= '0;
      dcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_step_r <= phase_step_nxt;
      fmt_r        <= fmt_nxt;
      stereo_r     <= stereo_nxt;
      prev_r       <= prev_nxt;
      phase_r      <= phase_nxt;
      run_r        <= run_nxt;
      dcnt_r       <= dcnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ch2_r      <= ch2_nxt;
    diff_r     <= diff_nxt;
    phsh_r     <= phsh_nxt;
    acc_r      <= acc_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  `DLR_ASSERT_NEXT(a_silent_stays_idle, in_tvalid && in_tready && in_tuser, state_r == ST_IDLE, "silent frame left idle")
  `DLR_ASSERT_NOW(a_mul_phase_below_one, state_r == ST_MUL, phase_r[PH_W-1:PF] == '0, "multiply with phase at or above one")
  `DLR_ASSERT_NEXT(a_run_cap_marks_last, (state_r == ST_EMIT) && out_free && (run_r == RW'(dlr_pkg::MAX_RUN - 1)), out_tvalid && out_tlast, "capped run without last flag")
  `DLR_ASSERT_NOW(a_idle_run_cleared, in_tready, run_r == '0, "run count not cleared when idle")

endmodule
